/* src/yrc_pkg.sv */
// yrc_pkg: widths, fixed-point weights, register map and saturation helper
// for the YUV/RGB pixel converter. No dependencies.
package yrc_pkg;

   localparam int SAMPLE_W = 8;
   localparam int PIXEL_W  = 24;
   localparam int TERM_W   = 19;   // largest weighted sum magnitude is below 2^18
   localparam int FRAC_W   = 8;
   localparam int SHR_W    = TERM_W - FRAC_W;
   localparam int OFS_W    = SHR_W + 1;
   localparam int CH_N     = 3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // word index decoded from paddr[2]
   localparam logic REG_TO_RGB = 1'b0;

   localparam logic MODE_TO_RGB = 1'b1;
   localparam logic MODE_TO_YUV = 1'b0;

   // YUV to RGB weights
   localparam logic signed [TERM_W-1:0] C_RV = 19'sd292;
   localparam logic signed [TERM_W-1:0] C_GU = -19'sd101;
   localparam logic signed [TERM_W-1:0] C_GV = -19'sd149;
   localparam logic signed [TERM_W-1:0] C_BU = 19'sd520;

   // RGB to YUV weights
   localparam logic signed [TERM_W-1:0] C_YR = 19'sd77;
   localparam logic signed [TERM_W-1:0] C_YG = 19'sd150;
   localparam logic signed [TERM_W-1:0] C_YB = 19'sd29;
   localparam logic signed [TERM_W-1:0] C_UR = -19'sd38;
   localparam logic signed [TERM_W-1:0] C_UG = -19'sd74;
   localparam logic signed [TERM_W-1:0] C_UB = 19'sd112;
   localparam logic signed [TERM_W-1:0] C_VR = 19'sd157;
   localparam logic signed [TERM_W-1:0] C_VG = -19'sd132;
   localparam logic signed [TERM_W-1:0] C_VB = -19'sd26;

   localparam logic signed [OFS_W-1:0] CHROMA_OFS = 12'sd128;

   typedef logic signed [TERM_W-1:0] term_type;

   function automatic logic [SAMPLE_W-1:0] sat8(input logic signed [OFS_W-1:0] x);
      logic [SAMPLE_W-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > $signed(OFS_W'(255))) begin
         r = '1;
      end else begin
         r = x[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

/* src/yrc_req_if.sv */
// yrc_req_if: input word channel (valid/ready plus YUV and packed RGB fields).
// Depends on yrc_pkg.
interface yrc_req_if;
   import yrc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] luma_in;
   logic [SAMPLE_W-1:0] u_in;
   logic [SAMPLE_W-1:0] v_in;
   logic [PIXEL_W-1:0]  rgb_in;

   modport source (output valid, luma_in, u_in, v_in, rgb_in, input ready);
   modport sink   (input valid, luma_in, u_in, v_in, rgb_in, output ready);
endinterface

/* src/yrc_rsp_if.sv */
// yrc_rsp_if: result word channel (valid/ready plus packed RGB and YUV fields).
// Depends on yrc_pkg.
interface yrc_rsp_if;
   import yrc_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIXEL_W-1:0]  rgb_out;
   logic [SAMPLE_W-1:0] luma_out;
   logic [SAMPLE_W-1:0] u_out;
   logic [SAMPLE_W-1:0] v_out;

   modport source (output valid, rgb_out, luma_out, u_out, v_out, input ready);
   modport sink   (input valid, rgb_out, luma_out, u_out, v_out, output ready);
endinterface

/* src/yuv_rgb_pixel_converter_unit.sv */
// yuv_rgb_pixel_converter_unit: four-stage YUV<->RGB pixel converter with APB
// direction register. Depends on yrc_pkg, yrc_req_if, yrc_rsp_if.
// One word per cycle unless rsp_chan.ready stalls; stages are input register, constant
// multiply, three-term add, shift/saturate output register.
// Each stage fills its bubble on its own, so input is taken while a result waits.
// Reset: synchronous; clears all valid bits and sets to_rgb to 1.
module yuv_rgb_pixel_converter_unit (
   input  logic                                clock,
   input  logic                                reset,
   yrc_req_if.sink                             req_chan,
   yrc_rsp_if.source                           rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [yrc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [yrc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [yrc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import yrc_pkg::*;

   // ---- configuration ----
   logic to_rgb_ff, to_rgb_in;

   assign pready = 1'b1;

   always_comb begin
      to_rgb_in = to_rgb_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_TO_RGB)) begin
         to_rgb_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_TO_RGB) begin
         prdata[0] = to_rgb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         to_rgb_ff <= MODE_TO_RGB;
      end else begin
         to_rgb_ff <= to_rgb_in;
      end
   end

   // ---- stage handshakes ----
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_chan.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_chan.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_chan.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---- stage 1: input register ----
   logic                mode1_ff;
   logic [SAMPLE_W-1:0] y1_ff, u1_ff, v1s_ff;
   logic [PIXEL_W-1:0]  rgb1_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req_chan.valid) begin
         mode1_ff <= to_rgb_ff;
         y1_ff    <= req_chan.luma_in;
         u1_ff    <= req_chan.u_in;
         v1s_ff   <= req_chan.v_in;
         rgb1_ff  <= req_chan.rgb_in;
      end
   end

   // ---- stage 2: constant products, three terms per channel ----
   term_type prod_a_in[CH_N], prod_b_in[CH_N], prod_c_in[CH_N];
   term_type prod_a_ff[CH_N], prod_b_ff[CH_N], prod_c_ff[CH_N];
   logic     mode2_ff;

   logic signed [SAMPLE_W-1:0] u_s, v_s;
   term_type                   u_t, v_t, ybase, r_t, g_t, b_t;

   always_comb begin
      // sample - 128 is the sample with its top bit flipped
      u_s   = {~u1_ff[SAMPLE_W-1], u1_ff[SAMPLE_W-2:0]};
      v_s   = {~v1s_ff[SAMPLE_W-1], v1s_ff[SAMPLE_W-2:0]};
      u_t   = TERM_W'(u_s);
      v_t   = TERM_W'(v_s);
      ybase = term_type'({y1_ff, {FRAC_W{1'b0}}});
      r_t   = term_type'(rgb1_ff[23:16]);
      g_t   = term_type'(rgb1_ff[15:8]);
      b_t   = term_type'(rgb1_ff[7:0]);
      if (mode1_ff == MODE_TO_RGB) begin
         prod_a_in[0] = ybase;
         prod_b_in[0] = TERM_W'(C_RV * v_t);
         prod_c_in[0] = '0;
         prod_a_in[1] = ybase;
         prod_b_in[1] = TERM_W'(C_GU * u_t);
         prod_c_in[1] = TERM_W'(C_GV * v_t);
         prod_a_in[2] = ybase;
         prod_b_in[2] = TERM_W'(C_BU * u_t);
         prod_c_in[2] = '0;
      end else begin
         prod_a_in[0] = TERM_W'(C_YR * r_t);
         prod_b_in[0] = TERM_W'(C_YG * g_t);
         prod_c_in[0] = TERM_W'(C_YB * b_t);
         prod_a_in[1] = TERM_W'(C_UR * r_t);
         prod_b_in[1] = TERM_W'(C_UG * g_t);
         prod_c_in[1] = TERM_W'(C_UB * b_t);
         prod_a_in[2] = TERM_W'(C_VR * r_t);
         prod_b_in[2] = TERM_W'(C_VG * g_t);
         prod_c_in[2] = TERM_W'(C_VB * b_t);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         mode2_ff  <= mode1_ff;
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         prod_c_ff <= prod_c_in;
      end
   end

   // ---- stage 3: weighted sums ----
   term_type sum_in[CH_N], sum_ff[CH_N];
   logic     mode3_ff;

   always_comb begin
      for (int k = 0; k < CH_N; k++) begin
         sum_in[k] = prod_a_ff[k] + prod_b_ff[k] + prod_c_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         mode3_ff <= mode2_ff;
         sum_ff   <= sum_in;
      end
   end

   // ---- stage 4: floor shift, chroma offset, saturate, output register ----
   logic signed [OFS_W-1:0] ofs_val[CH_N];
   logic [SAMPLE_W-1:0]     chan_sat[CH_N];
   logic [PIXEL_W-1:0]      rgb_out_in, rgb_out_ff;
   logic [SAMPLE_W-1:0]     luma_out_in, luma_out_ff;
   logic [SAMPLE_W-1:0]     u_out_in, u_out_ff;
   logic [SAMPLE_W-1:0]     v_out_in, v_out_ff;

   always_comb begin
      for (int k = 0; k < CH_N; k++) begin
         ofs_val[k] = OFS_W'($signed(sum_ff[k][TERM_W-1:FRAC_W]));
         // U and V carry the +128 offset in the RGB to YUV direction
         if ((mode3_ff == MODE_TO_YUV) && (k != 0)) begin
            ofs_val[k] = ofs_val[k] + CHROMA_OFS;
         end
         chan_sat[k] = sat8(ofs_val[k]);
      end
      rgb_out_in  = '0;
      luma_out_in = '0;
      u_out_in    = '0;
      v_out_in    = '0;
      if (mode3_ff == MODE_TO_RGB) begin
         rgb_out_in = {chan_sat[0], chan_sat[1], chan_sat[2]};
      end else begin
         luma_out_in = chan_sat[0];
         u_out_in    = chan_sat[1];
         v_out_in    = chan_sat[2];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         rgb_out_ff  <= rgb_out_in;
         luma_out_ff <= luma_out_in;
         u_out_ff    <= u_out_in;
         v_out_ff    <= v_out_in;
      end
   end

   assign rsp_chan.valid    = v4_ff;
   assign rsp_chan.rgb_out  = rgb_out_ff;
   assign rsp_chan.luma_out = luma_out_ff;
   assign rsp_chan.u_out    = u_out_ff;
   assign rsp_chan.v_out    = v_out_ff;

endmodule
